// File: rtl/etf_pkg.sv
// Shared types and constants of the Euler tour finder.
package etf_pkg;

  localparam int VW               = 6;
  localparam int DEG_W            = 7;
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 63;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CIRCUIT = 2'd1,
    OP_PATH    = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_TOUR = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_REPLY, S_DCLR, S_DRE, S_DRA, S_DWA, S_DRB, S_DWB,
    S_CRD, S_CEV, S_CEND, S_WRS, S_WSC, S_SCAN, S_FOUND, S_POP, S_POPW,
    S_ORD, S_OLD
  } state_e;

endpackage

// File: rtl/etf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module etf_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/euler_tour_finder_unit.sv
// Euler tour finder: multigraph edge store with a Hierholzer walk engine.
//
// Input channel s_axis: tuser carries the opcode, tdata the edge fields.
// Add edge writes one edge store entry per copy per cycle, then replies with
// a single transaction (status ok, or store full with nothing added).
// Clear resets the edge count and replies with one transaction.
// Find circuit / find path: degree table cleared, rebuilt from the edge list
// and checked vertex by vertex, then the walk runs: one edge slot scanned per
// cycle, plus found, pop and rescan states per push and pop; edge scanning over
// the edge store read port dominates. The tour is then streamed on m_axis,
// one vertex per transaction, tlast on the final one. A failing find gives one
// transaction.
// A new command is taken only once the previous one is fully handled; the
// output register lets it be taken while the last reply still waits.
// A stalled receiver holds the walk output in place; nothing is dropped.
// Reset clears the edge count, the directed register and all control state.
// The configuration write (cfg_we_i) must only occur while idle.
module euler_tour_finder_unit
  import etf_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // from_vertex[5:0], to_vertex[11:6], copies[17:12]
  input  logic [1:0]  s_axis_tuser_i,  // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // vertex[5:0]
  output logic [1:0]  m_axis_tuser_o,  // status[1:0]
  output logic        m_axis_tlast_o
);

  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW   = $clog2(MAX_EDGES + 1);
  localparam int TAW  = (MAX_EDGES + 1 > 1) ? $clog2(MAX_EDGES + 1) : 1;
  localparam int SW   = TW + 1;
  localparam int SPW  = $clog2(MAX_EDGES + 2);
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int VCW  = $clog2(MAX_VERTICES + 1);
  localparam int DGW  = 2 * DEG_W;

  state_e state_q, state_d;

  logic           directed_q;
  opcode_e        op_q;
  status_e        reply_q;
  logic [VW-1:0]  from_q, to_q;
  logic [TW-1:0]  total_q, rem_q, e_q;
  logic [VCW-1:0] v_q;
  logic [VW-1:0]  ea_q, eb_q;
  logic           bad_q, act_q, pick_q;
  logic [VW-1:0]  first_q, pickv_q;
  logic [1:0]     sc_q, ec_q, odd_q;
  logic [VW-1:0]  top_q, nb_q;
  logic [SW-1:0]  s_q;
  logic [SPW-1:0] sp_q, n_q, idx_q;
  logic [MAX_EDGES-1:0]    used_q;
  logic [MAX_VERTICES-1:0] svld_q;

  logic           out_valid_q, out_last_q;
  status_e        out_status_q;
  logic [VW-1:0]  out_vertex_q;
  logic           out_free;
  logic           out_load;

  // memory ports
  logic           ed_we, ed_re;
  logic [EAW-1:0] ed_waddr, ed_raddr;
  logic [11:0]    ed_rdata;
  logic           dg_we, dg_re;
  logic [VAW-1:0] dg_waddr, dg_raddr;
  logic [DGW-1:0] dg_wdata, dg_rdata;
  logic           sc_we, sc_re;
  logic [SW-1:0]  sc_rdata;
  logic           sk_we, sk_re;
  logic [EAW-1:0] sk_waddr, sk_raddr;
  logic [VW-1:0]  sk_rdata;
  logic           tr_we, tr_re;
  logic [VW-1:0]  tr_rdata;

  // input decode
  opcode_e        op_in;
  logic [VW-1:0]  from_in, to_in, cp_in;
  logic [TW:0]    cnt_in;
  logic           add_bad;
  logic           in_acc;

  assign op_in   = opcode_e'(s_axis_tuser_i);
  assign from_in = s_axis_tdata_i[5:0];
  assign to_in   = s_axis_tdata_i[11:6];
  assign cp_in   = s_axis_tdata_i[17:12];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign add_bad = ({1'b0, from_in} >= 7'(MAX_VERTICES)) ||
                   ({1'b0, to_in} >= 7'(MAX_VERTICES)) ||
                   (7'(total_q) + ((cp_in == '0) ? 7'd1 : {1'b0, cp_in}) >
                    7'(MAX_EDGES));
  assign cnt_in  = (cp_in == '0) ? (TW+1)'(1) : (TW+1)'(cp_in);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = out_free && ((state_q == S_REPLY) || (state_q == S_OLD));

  // degree word: out in the high half, in in the low half
  logic [DEG_W-1:0] din, dout;
  logic             d_up, d_dn, d_eq;
  assign din  = dg_rdata[DEG_W-1:0];
  assign dout = dg_rdata[DGW-1:DEG_W];
  assign d_eq = (din == dout);
  assign d_up = ({1'b0, dout} == {1'b0, din} + (DEG_W+1)'(1));
  assign d_dn = ({1'b0, din} == {1'b0, dout} + (DEG_W+1)'(1));

  logic act_v;
  assign act_v = directed_q ? (dout != '0) : (din != '0);

  logic           chk_fail;
  logic [VW-1:0]  start_v;
  always_comb begin
    chk_fail = bad_q;
    if (op_q == OP_PATH) begin
      if (directed_q) begin
        chk_fail = bad_q || (sc_q > 2'd1) || (ec_q > 2'd1);
      end else begin
        chk_fail = bad_q || ((odd_q != 2'd0) && (odd_q != 2'd2));
      end
    end
    start_v = pick_q ? pickv_q : first_q;
  end

  // scan step on the edge slot in s_q
  logic [SW-1:0]  slots, s_inc, s_new;
  logic [EAW-1:0] s_edge;
  logic [VW-1:0]  sa, sb, snb;
  logic           smatch, sdone;
  assign slots  = {total_q, 1'b0};
  assign s_inc  = s_q + SW'(1);
  assign s_edge = s_q[EAW:1];
  assign sa     = ed_rdata[5:0];
  assign sb     = ed_rdata[11:6];
  assign snb    = s_q[0] ? sa : sb;
  assign smatch = (s_q[0] ? (!directed_q && (sb == top_q)) : (sa == top_q)) &&
                  !used_q[s_edge];
  assign sdone  = s_inc >= slots;
  assign s_new  = svld_q[top_q[VAW-1:0]] ? sc_rdata : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_in)
            OP_ADD:   state_d = add_bad ? S_REPLY : S_ADD;
            OP_CLEAR: state_d = S_REPLY;
            default:  state_d = (total_q == '0) ? S_REPLY : S_DCLR;
          endcase
        end
      end
      S_ADD:   if (rem_q == TW'(1)) state_d = S_REPLY;
      S_REPLY: if (out_free) state_d = S_IDLE;
      S_DCLR:  if (v_q == VCW'(MAX_VERTICES - 1)) state_d = S_DRE;
      S_DRE:   state_d = S_DRA;
      S_DRA:   state_d = S_DWA;
      S_DWA:   state_d = S_DRB;
      S_DRB:   state_d = S_DWB;
      S_DWB:   state_d = (e_q + TW'(1) == total_q) ? S_CRD : S_DRE;
      S_CRD:   state_d = S_CEV;
      S_CEV:   state_d = (v_q == VCW'(MAX_VERTICES - 1)) ? S_CEND : S_CRD;
      S_CEND:  state_d = chk_fail ? S_REPLY : S_WRS;
      S_WRS:   state_d = S_WSC;
      S_WSC:   state_d = (s_new >= slots) ? S_POP : S_SCAN;
      S_SCAN: begin
        if (smatch)     state_d = S_FOUND;
        else if (sdone) state_d = S_POP;
      end
      S_FOUND: state_d = S_WRS;
      S_POP:   state_d = (sp_q == SPW'(1)) ? S_ORD : S_POPW;
      S_POPW:  state_d = S_WRS;
      S_ORD:   state_d = S_OLD;
      S_OLD: begin
        if (out_free) state_d = (idx_q == SPW'(1)) ? S_IDLE : S_ORD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ed_we    = (state_q == S_ADD);
    ed_waddr = total_q[EAW-1:0];
    ed_re    = 1'b0;
    ed_raddr = e_q[EAW-1:0];
    dg_we    = 1'b0;
    dg_waddr = v_q[VAW-1:0];
    dg_wdata = '0;
    dg_re    = 1'b0;
    dg_raddr = v_q[VAW-1:0];
    sc_we    = 1'b0;
    sc_re    = (state_q == S_WRS);
    sk_we    = (state_q == S_FOUND);
    sk_waddr = EAW'(sp_q - SPW'(1));
    sk_re    = 1'b0;
    sk_raddr = EAW'(sp_q - SPW'(2));
    tr_we    = (state_q == S_POP);
    tr_re    = (state_q == S_ORD);
    case (state_q)
      S_DCLR: dg_we = 1'b1;
      S_DRE:  ed_re = 1'b1;
      S_DRA: begin
        dg_re    = 1'b1;
        dg_raddr = ed_rdata[VAW-1:0];
      end
      S_DWA: begin
        dg_we    = 1'b1;
        dg_waddr = ea_q[VAW-1:0];
        dg_wdata = {dout + DEG_W'(1), din + DEG_W'(!directed_q)};
      end
      S_DRB: begin
        dg_re    = 1'b1;
        dg_raddr = eb_q[VAW-1:0];
      end
      S_DWB: begin
        dg_we    = 1'b1;
        dg_waddr = eb_q[VAW-1:0];
        dg_wdata = {dout + DEG_W'(!directed_q), din + DEG_W'(1)};
      end
      S_CRD:  dg_re = 1'b1;
      S_WSC: begin
        ed_re    = (s_new < slots);
        ed_raddr = s_new[EAW:1];
      end
      S_SCAN: begin
        sc_we    = smatch || sdone;
        ed_re    = !smatch && !sdone;
        ed_raddr = s_inc[EAW:1];
      end
      S_POP:  sk_re = (sp_q != SPW'(1));
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      directed_q   <= 1'b0;
      op_q         <= OP_ADD;
      reply_q      <= ST_OK;
      from_q       <= '0;
      to_q         <= '0;
      total_q      <= '0;
      rem_q        <= '0;
      e_q          <= '0;
      v_q          <= '0;
      ea_q         <= '0;
      eb_q         <= '0;
      bad_q        <= 1'b0;
      act_q        <= 1'b0;
      pick_q       <= 1'b0;
      first_q      <= '0;
      pickv_q      <= '0;
      sc_q         <= '0;
      ec_q         <= '0;
      odd_q        <= '0;
      top_q        <= '0;
      nb_q         <= '0;
      s_q          <= '0;
      sp_q         <= '0;
      n_q          <= '0;
      idx_q        <= '0;
      used_q       <= '0;
      svld_q       <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= ST_OK;
      out_vertex_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) directed_q <= cfg_wdata_i;
      if (out_valid_q && m_axis_tready_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= op_in;
            from_q  <= from_in;
            to_q    <= to_in;
            rem_q   <= cnt_in[TW-1:0];
            v_q     <= '0;
            e_q     <= '0;
            case (op_in)
              OP_ADD:   reply_q <= add_bad ? ST_FULL : ST_OK;
              OP_CLEAR: begin
                reply_q <= ST_OK;
                total_q <= '0;
              end
              default:  reply_q <= (total_q == '0) ? ST_EMPTY : ST_OK;
            endcase
          end
        end
        S_ADD: begin
          total_q <= total_q + TW'(1);
          rem_q   <= rem_q - TW'(1);
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= reply_q;
            out_vertex_q <= '0;
            out_last_q   <= 1'b1;
          end
        end
        S_DCLR: v_q <= v_q + VCW'(1);
        S_DRA: begin
          ea_q <= ed_rdata[5:0];
          eb_q <= ed_rdata[11:6];
        end
        S_DWB: begin
          e_q    <= e_q + TW'(1);
          v_q    <= '0;
          bad_q  <= 1'b0;
          act_q  <= 1'b0;
          pick_q <= 1'b0;
          first_q <= '0;
          pickv_q <= '0;
          sc_q   <= '0;
          ec_q   <= '0;
          odd_q  <= '0;
        end
        S_CEV: begin
          v_q <= v_q + VCW'(1);
          if (act_v && !act_q) begin
            act_q   <= 1'b1;
            first_q <= VW'(v_q);
          end
          if (op_q == OP_CIRCUIT) begin
            if (directed_q ? !d_eq : din[0]) bad_q <= 1'b1;
          end else if (directed_q) begin
            if (!(d_eq || d_up || d_dn)) bad_q <= 1'b1;
            if (d_up) begin
              if (sc_q != 2'd3) sc_q <= sc_q + 2'd1;
              if (!pick_q) begin
                pick_q  <= 1'b1;
                pickv_q <= VW'(v_q);
              end
            end
            if (d_dn && ec_q != 2'd3) ec_q <= ec_q + 2'd1;
          end else if (din[0]) begin
            if (odd_q != 2'd3) odd_q <= odd_q + 2'd1;
            if (!pick_q) begin
              pick_q  <= 1'b1;
              pickv_q <= VW'(v_q);
            end
          end
        end
        S_CEND: begin
          reply_q <= ST_NO_TOUR;
          top_q   <= start_v;
          sp_q    <= SPW'(1);
          n_q     <= '0;
          used_q  <= '0;
          svld_q  <= '0;
        end
        S_WSC: s_q <= s_new;
        S_SCAN: begin
          if (smatch || sdone) begin
            svld_q[top_q[VAW-1:0]] <= 1'b1;
          end
          if (smatch) begin
            used_q[s_edge] <= 1'b1;
            nb_q <= snb;
          end else if (!sdone) begin
            s_q <= s_inc;
          end
        end
        S_FOUND: begin
          top_q <= nb_q;
          sp_q  <= sp_q + SPW'(1);
        end
        S_POP: begin
          n_q   <= n_q + SPW'(1);
          sp_q  <= sp_q - SPW'(1);
          idx_q <= n_q + SPW'(1);
        end
        S_POPW: top_q <= sk_rdata;
        S_OLD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= ST_OK;
            out_vertex_q <= tr_rdata;
            out_last_q   <= (idx_q == SPW'(1));
            idx_q        <= idx_q - SPW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_vertex_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  etf_ram #(.W(12), .D(MAX_EDGES)) u_edges (
    .clk_i   (clk_i),
    .we_i    (ed_we),
    .waddr_i (ed_waddr),
    .wdata_i ({to_q, from_q}),
    .re_i    (ed_re),
    .raddr_i (ed_raddr),
    .rdata_o (ed_rdata)
  );

  etf_ram #(.W(DGW), .D(MAX_VERTICES)) u_degree (
    .clk_i   (clk_i),
    .we_i    (dg_we),
    .waddr_i (dg_waddr),
    .wdata_i (dg_wdata),
    .re_i    (dg_re),
    .raddr_i (dg_raddr),
    .rdata_o (dg_rdata)
  );

  etf_ram #(.W(SW), .D(MAX_VERTICES)) u_scan (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (top_q[VAW-1:0]),
    .wdata_i (s_inc),
    .re_i    (sc_re),
    .raddr_i (top_q[VAW-1:0]),
    .rdata_o (sc_rdata)
  );

  etf_ram #(.W(VW), .D(MAX_EDGES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (top_q),
    .re_i    (sk_re),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  etf_ram #(.W(VW), .D(MAX_EDGES + 1)) u_tour (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (TAW'(n_q)),
    .wdata_i (top_q),
    .re_i    (tr_re),
    .raddr_i (TAW'(idx_q - SPW'(1))),
    .rdata_o (tr_rdata)
  );

`ifndef NO_ASSERTIONS
  a_reply_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_OK) |->
      (m_axis_tlast_o && m_axis_tdata_o == 8'd0))
    else $error("error reply must be a single last transaction");
  a_idle_stack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (sp_q == '0 || sp_q == SPW'(1)) && (sp_q <= SPW'(1)))
    else $error("walk stack not drained");
  a_tour_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (n_q <= SPW'(MAX_EDGES)))
    else $error("tour longer than edge count plus one");
  a_push_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOUND) |=> ($countones(used_q) == $countones($past(used_q))))
    else $error("used marks changed outside scan");
`endif

endmodule
